FILE: hdl/tpd_pkg.sv
// Shared types and codes for the two-way priority dispatch block.
// No dependencies; imported by every RTL module of the block.
`default_nettype none

package tpd_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DISP,
        ST_POST
    } tpd_state_t;

    typedef enum logic [1:0] {
        STAT_ENQUEUED = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_GRANTED  = 2'd2,
        STAT_EMPTY    = 2'd3
    } tpd_status_t;

    localparam logic FUNC_ENQUEUE  = 1'b0;
    localparam logic FUNC_DISPATCH = 1'b1;

    localparam logic DIR_EAST = 1'b0;
    localparam logic DIR_WEST = 1'b1;

endpackage

`default_nettype wire

FILE: hdl/tpd_ram.sv
// Queue entry store: one write port, one read port, registered read data.
// Depends on tpd_pkg only for the common import convention.
`default_nettype none

module tpd_ram
    import tpd_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int WIDTH = 17
)
(
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: hdl/two_way_priority_dispatch_core.sv
// Top level: two ordered request queues in circular RAMs plus dispatcher FSM.
// Depends on tpd_pkg and tpd_ram.
//
//  channel | signals                                            | dir
//  --------+----------------------------------------------------+-----
//  in      | in_valid, in_stall, func, direction, priority_req, | in
//          | load_time, request_id                              |
//  out     | out_valid, out_stall, status, granted_id,          | out
//          | granted_direction, east_count, west_count          |
//
// Enqueue: the insertion walks the queue RAM one entry per cycle, shifting the
//   tail up behind the new entry, then posts the result.
// Dispatch: head reads, then result. Full queue or empty dispatch: straight to
//   the result. A stalled result holds the block until the output register frees.
// One item in flight; a finished result waits in the output register while the
// next item is taken. Reset clears fill counts and pointers; RAM needs no clear.
`default_nettype none

module two_way_priority_dispatch_core
    import tpd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64,
    parameter int ID_BITS     = 8,
    parameter int LOAD_BITS   = 8
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 func,
    input  wire logic                 direction,
    input  wire logic                 priority_req,
    input  wire logic [LOAD_BITS-1:0] load_time,
    input  wire logic [ID_BITS-1:0]   request_id,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic      [1:0]           status,
    output logic      [7:0]           granted_id,
    output logic                      granted_direction,
    output logic      [6:0]           east_count,
    output logic      [6:0]           west_count
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = 1 + LOAD_BITS + ID_BITS;

    tpd_state_t      state_reg, state_next;
    logic [AW-1:0]   east_head_reg, east_head_next, west_head_reg, west_head_next;
    logic [CW-1:0]   east_fill_reg, east_fill_next, west_fill_reg, west_fill_next;
    logic            last_west_reg, last_west_next;
    logic            granted_before_reg, granted_before_next;
    logic            dir_reg, dir_next;
    logic [CW-1:0]   ptr_reg, ptr_next;
    logic [EW-1:0]   carry_reg, carry_next;
    logic            ins_reg, ins_next;
    tpd_status_t     res_status_reg, res_status_next;
    logic [ID_BITS-1:0] res_id_reg, res_id_next;
    logic            res_dir_reg, res_dir_next;

    logic            out_valid_reg, out_valid_next;
    logic [1:0]      status_reg, status_next;
    logic [7:0]      granted_id_reg, granted_id_next;
    logic            granted_dir_reg, granted_dir_next;
    logic [6:0]      east_count_reg, east_count_next;
    logic [6:0]      west_count_reg, west_count_next;

    logic            east_we, west_we;
    logic [AW-1:0]   waddr, east_raddr, west_raddr;
    logic [EW-1:0]   east_rdata, west_rdata;

    logic [AW-1:0]   sel_head;
    logic [CW-1:0]   sel_fill;
    logic [EW-1:0]   sel_rdata;
    logic [AW-1:0]   scan_raddr;
    logic            scan_end, scan_hit, pick_west, slot_free;
    logic [CW+6:0]   east_fill_ext, west_fill_ext;
    logic [ID_BITS+7:0] res_id_ext;

    function automatic logic [AW-1:0] wrap_addr(input logic [AW-1:0] head,
                                                input logic [CW-1:0] ofs);
        logic [CW:0] s;
        s = (CW+1)'(head) + (CW+1)'(ofs);
        if (s >= (CW+1)'(QUEUE_DEPTH))
        begin
            s = s - (CW+1)'(QUEUE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    // true when the new request must be placed ahead of the waiting one
    function automatic logic goes_ahead(input logic [EW-1:0] waiting,
                                        input logic [EW-1:0] fresh);
        logic same;
        same = (waiting[EW-1] == fresh[EW-1])
            && (waiting[EW-2:ID_BITS] == fresh[EW-2:ID_BITS]);
        return (!waiting[EW-1] && fresh[EW-1])
            || (same && (waiting[ID_BITS-1:0] > fresh[ID_BITS-1:0]));
    endfunction

    tpd_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(EW)) u_east_ram (
        .clk   (clk),
        .we    (east_we),
        .waddr (waddr),
        .wdata (carry_reg),
        .raddr (east_raddr),
        .rdata (east_rdata)
    );

    tpd_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(EW)) u_west_ram (
        .clk   (clk),
        .we    (west_we),
        .waddr (waddr),
        .wdata (carry_reg),
        .raddr (west_raddr),
        .rdata (west_rdata)
    );

    assign sel_head   = dir_reg ? west_head_reg : east_head_reg;
    assign sel_fill   = dir_reg ? west_fill_reg : east_fill_reg;
    assign sel_rdata  = dir_reg ? west_rdata : east_rdata;
    assign scan_end   = (ptr_reg == sel_fill);
    assign scan_hit   = scan_end || ins_reg || goes_ahead(sel_rdata, carry_reg);
    assign waddr      = wrap_addr(sel_head, ptr_reg);
    assign scan_raddr = wrap_addr(sel_head, ptr_reg + CW'(1));
    assign slot_free  = !out_valid_reg || !out_stall;

    // read ahead one entry during the scan; otherwise keep heads on the port
    always_comb
    begin
        east_raddr = east_head_reg;
        west_raddr = west_head_reg;
        if (state_reg == ST_SCAN)
        begin
            east_raddr = scan_raddr;
            west_raddr = scan_raddr;
        end
    end

    always_comb
    begin
        if (east_fill_reg == '0)
        begin
            pick_west = 1'b1;
        end
        else if (west_fill_reg == '0)
        begin
            pick_west = 1'b0;
        end
        else if (east_rdata[EW-1] != west_rdata[EW-1])
        begin
            pick_west = west_rdata[EW-1];
        end
        else
        begin
            pick_west = granted_before_reg && !last_west_reg;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (func == FUNC_DISPATCH)
                    begin
                        if (east_fill_reg == '0 && west_fill_reg == '0)
                        begin
                            state_next = ST_POST;
                        end
                        else
                        begin
                            state_next = ST_DISP;
                        end
                    end
                    else if ((direction ? west_fill_reg : east_fill_reg)
                             == CW'(QUEUE_DEPTH))
                    begin
                        state_next = ST_POST;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_POST;
                end
            end
            ST_DISP:
            begin
                state_next = ST_POST;
            end
            ST_POST:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        east_head_next      = east_head_reg;
        west_head_next      = west_head_reg;
        east_fill_next      = east_fill_reg;
        west_fill_next      = west_fill_reg;
        last_west_next      = last_west_reg;
        granted_before_next = granted_before_reg;
        dir_next            = dir_reg;
        ptr_next            = ptr_reg;
        carry_next          = carry_reg;
        ins_next            = ins_reg;
        res_status_next     = res_status_reg;
        res_id_next         = res_id_reg;
        res_dir_next        = res_dir_reg;
        east_we             = 1'b0;
        west_we             = 1'b0;
        out_valid_next      = out_valid_reg && out_stall;
        status_next         = status_reg;
        granted_id_next     = granted_id_reg;
        granted_dir_next    = granted_dir_reg;
        east_count_next     = east_count_reg;
        west_count_next     = west_count_reg;
        east_fill_ext       = {7'd0, east_fill_reg};
        west_fill_ext       = {7'd0, west_fill_reg};
        res_id_ext          = {8'd0, res_id_reg};

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    dir_next     = direction;
                    ptr_next     = '0;
                    ins_next     = 1'b0;
                    carry_next   = {priority_req, load_time, request_id};
                    res_id_next  = '0;
                    res_dir_next = DIR_EAST;
                    if (func == FUNC_DISPATCH)
                    begin
                        res_status_next = STAT_EMPTY;
                    end
                    else if ((direction ? west_fill_reg : east_fill_reg)
                             == CW'(QUEUE_DEPTH))
                    begin
                        res_status_next = STAT_FULL;
                    end
                    else
                    begin
                        res_status_next = STAT_ENQUEUED;
                    end
                end
            end
            ST_SCAN:
            begin
                ptr_next = ptr_reg + CW'(1);
                if (scan_hit)
                begin
                    east_we    = (dir_reg == DIR_EAST);
                    west_we    = (dir_reg == DIR_WEST);
                    carry_next = sel_rdata;
                    ins_next   = 1'b1;
                end
                if (scan_end)
                begin
                    if (dir_reg == DIR_WEST)
                    begin
                        west_fill_next = west_fill_reg + CW'(1);
                    end
                    else
                    begin
                        east_fill_next = east_fill_reg + CW'(1);
                    end
                end
            end
            ST_DISP:
            begin
                res_status_next     = STAT_GRANTED;
                res_dir_next        = pick_west;
                last_west_next      = pick_west;
                granted_before_next = 1'b1;
                if (pick_west)
                begin
                    res_id_next    = west_rdata[ID_BITS-1:0];
                    west_head_next = wrap_addr(west_head_reg, CW'(1));
                    west_fill_next = west_fill_reg - CW'(1);
                end
                else
                begin
                    res_id_next    = east_rdata[ID_BITS-1:0];
                    east_head_next = wrap_addr(east_head_reg, CW'(1));
                    east_fill_next = east_fill_reg - CW'(1);
                end
            end
            ST_POST:
            begin
                if (slot_free)
                begin
                    out_valid_next   = 1'b1;
                    status_next      = res_status_reg;
                    granted_id_next  = res_id_ext[7:0];
                    granted_dir_next = res_dir_reg;
                    east_count_next  = east_fill_ext[6:0];
                    west_count_next  = west_fill_ext[6:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            east_head_reg      <= '0;
            west_head_reg      <= '0;
            east_fill_reg      <= '0;
            west_fill_reg      <= '0;
            last_west_reg      <= 1'b0;
            granted_before_reg <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            east_head_reg      <= east_head_next;
            west_head_reg      <= west_head_next;
            east_fill_reg      <= east_fill_next;
            west_fill_reg      <= west_fill_next;
            last_west_reg      <= last_west_next;
            granted_before_reg <= granted_before_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dir_reg         <= dir_next;
        ptr_reg         <= ptr_next;
        carry_reg       <= carry_next;
        ins_reg         <= ins_next;
        res_status_reg  <= res_status_next;
        res_id_reg      <= res_id_next;
        res_dir_reg     <= res_dir_next;
        status_reg      <= status_next;
        granted_id_reg  <= granted_id_next;
        granted_dir_reg <= granted_dir_next;
        east_count_reg  <= east_count_next;
        west_count_reg  <= west_count_next;
    end

    assign in_stall          = (state_reg != ST_IDLE);
    assign out_valid         = out_valid_reg;
    assign status            = status_reg;
    assign granted_id        = granted_id_reg;
    assign granted_direction = granted_dir_reg;
    assign east_count        = east_count_reg;
    assign west_count        = west_count_reg;

endmodule

`default_nettype wire

FILE: hdl/tpd_checker.sv
// Port-level checks for two_way_priority_dispatch_core, attached by bind.
// Depends on tpd_pkg for status codes.
`default_nettype none

module tpd_checker
    import tpd_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [1:0] status,
    input wire logic [7:0] granted_id,
    input wire logic       granted_direction,
    input wire logic [6:0] east_count,
    input wire logic [6:0] west_count
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(granted_id))
        else $error("stalled result changed");

    a_empty_counts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STAT_EMPTY |-> east_count == 7'd0 && west_count == 7'd0)
        else $error("nothing-waiting result with nonzero counts");

    a_no_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STAT_GRANTED |-> granted_id == 8'd0
            && granted_direction == 1'b0)
        else $error("grant fields set without a grant");

endmodule

bind two_way_priority_dispatch_core tpd_checker u_tpd_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .status            (status),
    .granted_id        (granted_id),
    .granted_direction (granted_direction),
    .east_count        (east_count),
    .west_count        (west_count)
);

`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking bench for two_way_priority_dispatch_core: a directed table, then random traffic.
// A behavioral queue predictor sits beside the block. Depends on tpd_pkg and the block's RTL.

module tb_top;
    import tpd_pkg::*;

    localparam int DEPTH      = 64;
    localparam int WDOG_LIMIT = 20000;

    typedef struct packed {
        logic       pri;
        logic [7:0] load;
        logic [7:0] id;
    } req_t;

    typedef struct packed {
        tpd_status_t st;
        logic [7:0]  gid;
        logic        gdir;
        logic [6:0]  ecnt;
        logic [6:0]  wcnt;
    } verdict_t;

    typedef struct packed {
        logic       fn;
        logic       dir;
        logic       pri;
        logic [7:0] load;
        logic [7:0] id;
    } op_t;

    // directed row: operation plus an optional hand-typed expectation
    typedef struct packed {
        op_t      op;
        logic     known;
        verdict_t exp;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic func = 1'b0;
    logic direction = 1'b0;
    logic priority_req = 1'b0;
    logic [7:0] load_time = '0;
    logic [7:0] request_id = '0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    logic [1:0] status;
    logic [7:0] granted_id;
    logic granted_direction;
    logic [6:0] east_count;
    logic [6:0] west_count;

    two_way_priority_dispatch_core i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .direction(direction), .priority_req(priority_req),
        .load_time(load_time), .request_id(request_id),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .granted_id(granted_id), .granted_direction(granted_direction),
        .east_count(east_count), .west_count(west_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // predictor state
    req_t     east_q[$];
    req_t     west_q[$];
    logic     last_west;
    logic     any_grant;
    verdict_t pending_verdicts[$];
    verdict_t typed_verdicts[$];
    logic     typed_flags[$];
    int       mismatches = 0;
    int       idle_cycles = 0;
    int       stall_left = 0;
    bit       quiet = 1'b0;

    function automatic void insert_sorted(ref req_t q[$], input req_t r);
        int pos;
        pos = 0;
        if (q.size() > 0 && !(q[0].pri < r.pri ||
            (q[0].pri == r.pri && q[0].load == r.load && q[0].id > r.id)))
        begin
            pos = 1;
            while (pos < q.size() && q[pos].pri >= r.pri)
            begin
                if (q[pos].pri == r.pri && q[pos].load == r.load && q[pos].id > r.id)
                    break;
                pos++;
            end
        end
        q.insert(pos, r);
    endfunction

    function automatic verdict_t predict_dispatch(op_t op);
        verdict_t v;
        req_t     r;
        logic     pick_west;
        v = '0;
        if (op.fn == FUNC_ENQUEUE)
        begin
            r = '{pri: op.pri, load: op.load, id: op.id};
            if (op.dir == DIR_EAST)
            begin
                if (east_q.size() >= DEPTH) v.st = STAT_FULL;
                else begin insert_sorted(east_q, r); v.st = STAT_ENQUEUED; end
            end
            else
            begin
                if (west_q.size() >= DEPTH) v.st = STAT_FULL;
                else begin insert_sorted(west_q, r); v.st = STAT_ENQUEUED; end
            end
        end
        else if (east_q.size() == 0 && west_q.size() == 0)
            v.st = STAT_EMPTY;
        else
        begin
            if (east_q.size() == 0) pick_west = 1'b1;
            else if (west_q.size() == 0) pick_west = 1'b0;
            else if (east_q[0].pri != west_q[0].pri) pick_west = west_q[0].pri;
            else pick_west = any_grant && !last_west;
            if (pick_west) r = west_q.pop_front();
            else r = east_q.pop_front();
            v.gid     = r.id;
            v.gdir    = pick_west;
            last_west = pick_west;
            any_grant = 1'b1;
            v.st      = STAT_GRANTED;
        end
        v.ecnt = 7'(east_q.size());
        v.wcnt = 7'(west_q.size());
        return v;
    endfunction

    // input side: record each accepted transfer
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            pending_verdicts.push_back(predict_dispatch(
                '{fn: func, dir: direction, pri: priority_req,
                  load: load_time, id: request_id}));
    end

    // output side: compare against the oldest expectation
    always @(posedge clk)
    begin
        verdict_t e;
        verdict_t got;
        logic     known;
        verdict_t typed;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{st: tpd_status_t'(status), gid: granted_id, gdir: granted_direction,
                    ecnt: east_count, wcnt: west_count};
            if (pending_verdicts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end
            else
            begin
                e = pending_verdicts.pop_front();
                known = 1'b0;
                typed = '0;
                if (typed_flags.size() > 0)
                begin
                    known = typed_flags.pop_front();
                    typed = typed_verdicts.pop_front();
                end
                if (known && typed != e) e = typed;
                if (got != e)
                begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: expected %p got %p", e, got);
                end
            end
        end
    end

    // random receiver stalls in bursts of random length
    always @(negedge clk)
    begin
        if (quiet)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 1)
            stall_left <= stall_left - 1;
        else if (stall_left == 1)
        begin
            stall_left <= 0;
            out_stall  <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left <= int'($urandom_range(1, 6));
            out_stall  <= 1'b1;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // valid stays high between back-to-back items; it drops only for gaps
    task automatic send(op_t op);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            for (gap = $urandom_range(1, 6); gap > 0; gap--) @(negedge clk);
        end
        in_valid     <= 1'b1;
        func         <= op.fn;
        direction    <= op.dir;
        priority_req <= op.pri;
        load_time    <= op.load;
        request_id   <= op.id;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic op_t enq(logic dir, logic pri, logic [7:0] ld, logic [7:0] id);
        return '{fn: FUNC_ENQUEUE, dir: dir, pri: pri, load: ld, id: id};
    endfunction

    function automatic op_t disp();
        return '{fn: FUNC_DISPATCH, dir: 1'($urandom_range(0, 1)),
                 pri: 1'($urandom_range(0, 1)),
                 load: 8'($urandom_range(0, 255)), id: 8'($urandom_range(0, 255))};
    endfunction

    function automatic op_t rand_enq(int dir);
        op_t o;
        o = enq(1'(dir < 0 ? int'($urandom_range(0, 1)) : dir),
                1'($urandom_range(0, 1)),
                8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                             : $urandom_range(0, 3)),
                8'($urandom_range(0, 255)));
        return o;
    endfunction

    function automatic row_t typed_row(op_t op, tpd_status_t st, logic [7:0] gid,
                                       logic gd, int ec, int wc);
        return '{op: op, known: 1'b1,
                 exp: '{st: st, gid: gid, gdir: gd, ecnt: 7'(ec), wcnt: 7'(wc)}};
    endfunction

    function automatic row_t plain_row(op_t op);
        return '{op: op, known: 1'b0, exp: '0};
    endfunction

    row_t directed[$];

    initial
    begin
        int i;
        int k;
        int n;
        int burst;
        last_west = 1'b0;
        any_grant = 1'b0;
        directed = '{
            typed_row(disp(), STAT_EMPTY, 8'd0, 1'b0, 0, 0),
            typed_row(enq(DIR_EAST, 1'b0, 8'd0, 8'd255), STAT_ENQUEUED, 8'd0, 1'b0, 1, 0),
            typed_row(enq(DIR_WEST, 1'b0, 8'd255, 8'd0), STAT_ENQUEUED, 8'd0, 1'b0, 1, 1),
            // equal priority heads, nothing granted yet: east first
            typed_row(disp(), STAT_GRANTED, 8'd255, 1'b0, 0, 1),
            plain_row(enq(DIR_EAST, 1'b0, 8'd7, 8'd9)),
            // tie now goes west, opposite of last grant
            typed_row(disp(), STAT_GRANTED, 8'd0, 1'b1, 1, 0),
            plain_row(enq(DIR_WEST, 1'b1, 8'd7, 8'd40)),
            plain_row(enq(DIR_WEST, 1'b1, 8'd7, 8'd20)),
            plain_row(enq(DIR_WEST, 1'b1, 8'd8, 8'd10)),
            plain_row(enq(DIR_WEST, 1'b0, 8'd7, 8'd1)),
            plain_row(enq(DIR_EAST, 1'b1, 8'd7, 8'd30)),
            plain_row(disp()), plain_row(disp()), plain_row(disp()),
            plain_row(disp()), plain_row(disp()), plain_row(disp()),
            typed_row(disp(), STAT_EMPTY, 8'd0, 1'b0, 0, 0)
        };

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[j])
        begin
            typed_flags.push_back(directed[j].known);
            typed_verdicts.push_back(directed[j].exp);
            send(directed[j].op);
        end

        // fill east to the brim and beyond, then drain, to hit the full case
        for (i = 0; i < DEPTH + 2; i++) send(rand_enq(DIR_EAST));
        for (i = 0; i < 3; i++) send(rand_enq(DIR_WEST));
        for (i = 0; i < DEPTH + 5; i++) send(disp());

        // random part: bursts of enqueues followed by dispatches
        n = 0;
        while (n < 260)
        begin
            if (n > 200) quiet = 1'b1;
            burst = $urandom_range(1, 12);
            for (k = 0; k < burst; k++) begin send(rand_enq(-1)); n++; end
            burst = $urandom_range(1, 12);
            for (k = 0; k < burst; k++) begin send(disp()); n++; end
        end
        in_valid <= 1'b0;

        while (pending_verdicts.size() > 0) @(posedge clk);
        repeat (80) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
